// File: rtl/lkpt_pkg.sv
// ----------------------------------------------------------------------------
// lkpt_pkg
// Shared constants and codes of the Lucas-Kanade point tracker.
// ----------------------------------------------------------------------------
package lkpt_pkg;

	localparam int DEF_MAX_WIDTH       = 256;
	localparam int DEF_MAX_HEIGHT      = 256;
	localparam int DEF_MAX_WINDOW_HALF = 7;
	localparam int PIX_W               = 8;
	localparam int DEF_RAM_DEPTH       = 256;
	localparam int LK_STEPS            = 5;

	// Item kinds carried in tuser of the input side.
	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_SWAP  = 2'd1;
	localparam logic [1:0] MODE_TRACK = 2'd2;

	// Result status carried in tuser of the output side.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ILL   = 2'd1;
	localparam logic [1:0] ST_LARGE = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WHALF  = 2'd2;

	// BT.601 luma weights scaled by 2^16.
	localparam logic [15:0] LUMA_R = 16'd19595;
	localparam logic [15:0] LUMA_G = 16'd38470;
	localparam logic [15:0] LUMA_B = 16'd7471;

	// Limits in Q.8 units; SMALL_SQ and LARGE_SQ are squared limits in Q.16 units.
	localparam longint DISP_LIMIT  = 64'sd1099511627776;
	localparam int     SMALL_STEP  = 26;
	localparam int     SMALL_SQ    = 656;
	localparam int     LARGE_AXIS  = 25600;
	localparam int     LARGE_SQ    = 655360000;
	localparam int     OUT_MAX     = 131071;
	localparam int     OUT_MIN     = -131072;

endpackage

// File: rtl/lkpt_ram.sv
// ----------------------------------------------------------------------------
// lkpt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lkpt_ram #(
	parameter int WIDTH = lkpt_pkg::PIX_W,
	parameter int DEPTH = lkpt_pkg::DEF_RAM_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	import lkpt_pkg::*;

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/lucas_kanade_point_tracker.sv
// Load word: stored in the current bank if in range. Swap word, unused mode: done in idle.
// A track word runs up to five steps, each a window pass (used pixels are read, multiplied,
// summed; border pixels and lookups leaving the frame are skipped), the solve products, the
// determinant, two bit-serial divisions and an update; a zero determinant jumps to output.
// A range check then the output, which waits for a held result to go; the next word waits.
// Reset restores the register defaults and makes bank a current; banks are not cleared.
// ----------------------------------------------------------------------------
// lucas_kanade_point_tracker
// Luma frame loader with an iterative Lucas-Kanade point tracker.
// ----------------------------------------------------------------------------
module lucas_kanade_point_tracker #(
	parameter int MAX_WIDTH       = lkpt_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT      = lkpt_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW_HALF = lkpt_pkg::DEF_MAX_WINDOW_HALF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_address[15:0], red[23:16], green[31:24], blue[39:32],
	// point_x[55:40], point_y[71:56]
	input  logic [71:0] s_tdata,
	// mode[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// new_x[17:0], new_y[35:18], zero fill[39:36]
	output logic [39:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import lkpt_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int HW    = $clog2(MAX_WINDOW_HALF + 1);
	localparam int DXW   = HW + 1;
	localparam int NPIX  = (2 * MAX_WINDOW_HALF + 1) * (2 * MAX_WINDOW_HALF + 1);
	localparam int SW    = $clog2(NPIX * 65025) + 1;
	localparam int PW    = 2 * SW;
	localparam int NW    = PW + 10;
	localparam int QCW   = $clog2(NW + 1);
	localparam int UW    = 42;

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_LOAD  = 16'h0002,
		S_PIX0  = 16'h0004,
		S_PIX1  = 16'h0008,
		S_PIX2  = 16'h0010,
		S_READ  = 16'h0020,
		S_MUL   = 16'h0040,
		S_ACC   = 16'h0080,
		S_SOLVE = 16'h0100,
		S_DET   = 16'h0200,
		S_DINIT = 16'h0400,
		S_DIV   = 16'h0800,
		S_DEND  = 16'h1000,
		S_UPD   = 16'h2000,
		S_SQ    = 16'h4000,
		S_OUT   = 16'h8000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [8:0]    cfg_w_q, cfg_h_q;
	logic [2:0]    cfg_wh_q;
	logic [8:0]    w_e, h_e;
	logic [HW-1:0] wh_e;

	// Bank control and load path.
	logic          cur_sel_q;
	logic [15:0]   waddr_q;
	logic [7:0]    luma_q;
	logic          wok_q;
	logic [23:0]   luma_sum;
	logic          addr_ok;

	// Track context.
	logic [7:0]           x0_q, y0_q;
	logic [15:0]          ptx_q, pty_q;
	logic signed [UW-1:0] u_q, v_q;
	logic [2:0]           step_q;
	logic [1:0]           status_q;
	logic signed [DXW-1:0] dx_q, dy_q;
	logic signed [DXW-1:0] wh_pos;
	logic                  last_pix;

	// Pixel pipeline.
	logic signed [11:0] px_c, py_c;
	logic               border;
	logic [8:0]         px_q, py_q, cx_q, cy_q;
	logic signed [43:0] wx_c, wy_c, cx_c, cy_c;
	logic               cok;
	logic [18:0]        idx_c, cidx_c;
	logic [AW-1:0]      idx_q, cidx_q, pa_c;
	logic [2:0]         rcnt_q;
	logic [7:0]         pv_q [5];
	logic [7:0]         cv_q;
	logic signed [8:0]  gx_c, gy_c, it_c;
	logic signed [17:0] gxx_q, gxy_q, gyy_q, gxit_q, gyit_q;
	logic signed [SW-1:0] sxx_q, sxy_q, syy_q, bx_q, by_q;

	// Solve.
	logic [2:0]           mstep_q;
	logic signed [SW-1:0] ma, mb;
	logic signed [PW-1:0] mp_q [8];
	logic signed [PW-1:0] det_c, nxd_c, nyd_c;
	logic [PW-1:0]        det_q;
	logic signed [NW-1:0] nx_q, ny_q, dn_c;
	logic [NW-1:0]        dmag_c;
	logic                 dsel_q;
	logic                 neg_q;
	logic [NW-1:0]        quo_q;
	logic [PW-1:0]        rem_q;
	logic [PW:0]          shf_c;
	logic                 qbit_c;
	logic [QCW-1:0]       dcnt_q;
	logic signed [NW:0]   du_q, dv_q, dq_c;
	logic signed [NW+1:0] su_c, sv_c;
	logic signed [5:0]    du6, dv6;
	logic signed [11:0]   du_sq, dv_sq;
	logic                 stop_c;

	// Output.
	logic signed [42:0] ox_c, oy_c;
	logic [17:0]        ox_t, oy_t;
	logic               big_c;
	logic [1:0]         st_fin;

	// Banks.
	logic                we_a, we_b;
	logic [AW-1:0]       ra_a, ra_b;
	logic [PIX_W-1:0]    rd_a, rd_b, prv_rd, cur_rd;

	function automatic logic signed [43:0] rnd_q8(input logic signed [43:0] a);
		logic signed [43:0] n;
		begin
			n = -a;
			if (a >= 0) begin
				rnd_q8 = (a + 44'sd128) >>> 8;
			end else begin
				rnd_q8 = -((n + 44'sd128) >>> 8);
			end
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == S_IDLE);

	always_comb begin
		if (int'(cfg_w_q) < 3) begin
			w_e = 9'd3;
		end else if (int'(cfg_w_q) > MAX_WIDTH) begin
			w_e = 9'(MAX_WIDTH);
		end else begin
			w_e = cfg_w_q;
		end
		if (int'(cfg_h_q) < 3) begin
			h_e = 9'd3;
		end else if (int'(cfg_h_q) > MAX_HEIGHT) begin
			h_e = 9'(MAX_HEIGHT);
		end else begin
			h_e = cfg_h_q;
		end
		if (cfg_wh_q == 3'd0) begin
			wh_e = HW'(1);
		end else if (int'(cfg_wh_q) > MAX_WINDOW_HALF) begin
			wh_e = HW'(MAX_WINDOW_HALF);
		end else begin
			wh_e = HW'(cfg_wh_q);
		end
	end

	assign luma_sum = {8'b0, LUMA_R} * {16'b0, s_tdata[23:16]}
		+ {8'b0, LUMA_G} * {16'b0, s_tdata[31:24]}
		+ {8'b0, LUMA_B} * {16'b0, s_tdata[39:32]};
	assign addr_ok = int'(s_tdata[15:0]) < DEPTH;

	// Window position and border test.
	assign wh_pos   = $signed({1'b0, wh_e});
	assign last_pix = (dx_q == wh_pos) && (dy_q == wh_pos);
	assign px_c     = $signed({4'b0, x0_q}) + 12'(dx_q);
	assign py_c     = $signed({4'b0, y0_q}) + 12'(dy_q);
	assign border   = (px_c < 12'sd1) || (px_c >= $signed({3'b0, w_e}) - 12'sd1)
		|| (py_c < 12'sd1) || (py_c >= $signed({3'b0, h_e}) - 12'sd1);

	// Warped lookup, rounded half away from zero.
	assign wx_c = $signed({27'b0, px_q, 8'b0}) + 44'(u_q);
	assign wy_c = $signed({27'b0, py_q, 8'b0}) + 44'(v_q);
	assign cx_c = rnd_q8(wx_c);
	assign cy_c = rnd_q8(wy_c);
	assign cok  = (cx_c >= 44'sd0) && (cx_c < $signed({35'b0, w_e}))
		&& (cy_c >= 44'sd0) && (cy_c < $signed({35'b0, h_e}));
	assign idx_c  = {10'b0, py_q} * {10'b0, w_e} + {10'b0, px_q};
	assign cidx_c = {10'b0, cy_q} * {10'b0, w_e} + {10'b0, cx_q};

	// Neighbor and centre addresses in the previous bank, one per read cycle.
	always_comb begin
		case (rcnt_q)
			3'd0:    pa_c = idx_q + AW'(1);
			3'd1:    pa_c = idx_q - AW'(1);
			3'd2:    pa_c = idx_q + AW'(w_e);
			3'd3:    pa_c = idx_q - AW'(w_e);
			default: pa_c = idx_q;
		endcase
	end

	assign we_a   = (state_q == S_LOAD) && wok_q && !cur_sel_q;
	assign we_b   = (state_q == S_LOAD) && wok_q && cur_sel_q;
	assign ra_a   = cur_sel_q ? pa_c : cidx_q;
	assign ra_b   = cur_sel_q ? cidx_q : pa_c;
	assign prv_rd = cur_sel_q ? rd_a : rd_b;
	assign cur_rd = cur_sel_q ? rd_b : rd_a;

	lkpt_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (AW'(waddr_q)),
		.wdata (luma_q),
		.raddr (ra_a),
		.rdata (rd_a)
	);

	lkpt_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_bank_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (AW'(waddr_q)),
		.wdata (luma_q),
		.raddr (ra_b),
		.rdata (rd_b)
	);

	assign gx_c = $signed({1'b0, pv_q[0]}) - $signed({1'b0, pv_q[1]});
	assign gy_c = $signed({1'b0, pv_q[2]}) - $signed({1'b0, pv_q[3]});
	assign it_c = $signed({1'b0, cv_q}) - $signed({1'b0, pv_q[4]});

	// Shared multiplier of the solve and the final range check.
	always_comb begin
		case (mstep_q)
			3'd0:    begin ma = sxx_q;    mb = syy_q;    end
			3'd1:    begin ma = sxy_q;    mb = sxy_q;    end
			3'd2:    begin ma = syy_q;    mb = bx_q;     end
			3'd3:    begin ma = sxy_q;    mb = by_q;     end
			3'd4:    begin ma = sxx_q;    mb = by_q;     end
			3'd5:    begin ma = sxy_q;    mb = bx_q;     end
			3'd6:    begin ma = SW'(u_q); mb = SW'(u_q); end
			default: begin ma = SW'(v_q); mb = SW'(v_q); end
		endcase
	end

	assign det_c = mp_q[0] - mp_q[1];
	assign nxd_c = mp_q[2] - mp_q[3];
	assign nyd_c = mp_q[4] - mp_q[5];

	// Restoring divider, one quotient bit per cycle.
	assign dn_c   = dsel_q ? ny_q : nx_q;
	assign dmag_c = (dn_c < 0 ? NW'(-dn_c) : NW'(dn_c)) + NW'(det_q >> 1);
	assign shf_c  = {rem_q, quo_q[NW-1]};
	assign qbit_c = shf_c >= {1'b0, det_q};
	assign dq_c   = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

	assign su_c  = (NW+2)'(u_q) + (NW+2)'(du_q);
	assign sv_c  = (NW+2)'(v_q) + (NW+2)'(dv_q);
	assign du6   = du_q[5:0];
	assign dv6   = dv_q[5:0];
	assign du_sq = du6 * du6;
	assign dv_sq = dv6 * dv6;
	assign stop_c = (du_q > -SMALL_STEP) && (du_q < SMALL_STEP)
		&& (dv_q > -SMALL_STEP) && (dv_q < SMALL_STEP)
		&& (int'(du_sq) + int'(dv_sq) < SMALL_SQ);

	assign big_c = (u_q >= LARGE_AXIS) || (u_q <= -LARGE_AXIS)
		|| (v_q >= LARGE_AXIS) || (v_q <= -LARGE_AXIS)
		|| ((mp_q[6] + mp_q[7]) >= PW'(LARGE_SQ));
	assign st_fin = (status_q == ST_ILL) ? ST_ILL : (big_c ? ST_LARGE : ST_OK);
	assign ox_c   = 43'(u_q) + $signed({27'b0, ptx_q});
	assign oy_c   = 43'(v_q) + $signed({27'b0, pty_q});
	assign ox_t   = (ox_c > OUT_MAX) ? 18'(OUT_MAX) : ((ox_c < OUT_MIN) ? 18'(OUT_MIN) : ox_c[17:0]);
	assign oy_t   = (oy_c > OUT_MAX) ? 18'(OUT_MAX) : ((oy_c < OUT_MIN) ? 18'(OUT_MIN) : oy_c[17:0]);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q  <= 9'd256;
			cfg_h_q  <= 9'd256;
			cfg_wh_q <= 3'd4;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:  cfg_w_q  <= cfg_data;
				REG_HEIGHT: cfg_h_q  <= cfg_data;
				REG_WHALF:  cfg_wh_q <= cfg_data[2:0];
				default:    ;
			endcase
		end
	end

	// Control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cur_sel_q <= 1'b0;
			m_tvalid  <= 1'b0;
			rcnt_q    <= 3'd0;
			mstep_q   <= 3'd0;
			dcnt_q    <= '0;
			dsel_q    <= 1'b0;
			step_q    <= 3'd0;
		end else begin
			if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						case (s_tuser)
							MODE_LOAD:  state_q <= S_LOAD;
							MODE_SWAP:  cur_sel_q <= !cur_sel_q;
							MODE_TRACK: begin
								step_q  <= 3'd0;
								state_q <= S_PIX0;
							end
							default: ;
						endcase
					end
				end
				S_LOAD: state_q <= S_IDLE;
				S_PIX0: begin
					if (!border) begin
						state_q <= S_PIX1;
					end else if (last_pix) begin
						mstep_q <= 3'd0;
						state_q <= S_SOLVE;
					end
				end
				S_PIX1: begin
					if (cok) begin
						state_q <= S_PIX2;
					end else if (last_pix) begin
						mstep_q <= 3'd0;
						state_q <= S_SOLVE;
					end else begin
						state_q <= S_PIX0;
					end
				end
				S_PIX2: begin
					rcnt_q  <= 3'd0;
					state_q <= S_READ;
				end
				S_READ: begin
					rcnt_q <= rcnt_q + 3'd1;
					if (rcnt_q == 3'd5) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_ACC;
				S_ACC: begin
					if (last_pix) begin
						mstep_q <= 3'd0;
						state_q <= S_SOLVE;
					end else begin
						state_q <= S_PIX0;
					end
				end
				S_SOLVE: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd5) begin
						state_q <= S_DET;
					end
				end
				S_DET: begin
					dsel_q <= 1'b0;
					if (det_c == '0) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_DINIT;
					end
				end
				S_DINIT: begin
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + QCW'(1);
					if (dcnt_q == QCW'(NW - 1)) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: begin
					dsel_q  <= 1'b1;
					state_q <= dsel_q ? S_UPD : S_DINIT;
				end
				S_UPD: begin
					step_q <= step_q + 3'd1;
					if (stop_c || step_q == 3'(LK_STEPS - 1)) begin
						mstep_q <= 3'd6;
						state_q <= S_SQ;
					end else begin
						state_q <= S_PIX0;
					end
				end
				S_SQ: begin
					mstep_q <= mstep_q + 3'd1;
					if (mstep_q == 3'd7) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					// A result word still waiting is taken first.
					if (!m_tvalid) begin
						m_tvalid <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				waddr_q <= s_tdata[15:0];
				luma_q  <= luma_sum[23:16];
				wok_q   <= addr_ok;
				ptx_q   <= s_tdata[55:40];
				pty_q   <= s_tdata[71:56];
				x0_q    <= s_tdata[55:48];
				y0_q    <= s_tdata[71:64];
				u_q     <= '0;
				v_q     <= '0;
				status_q <= ST_OK;
				dx_q    <= -wh_pos;
				dy_q    <= -wh_pos;
				sxx_q   <= '0;
				sxy_q   <= '0;
				syy_q   <= '0;
				bx_q    <= '0;
				by_q    <= '0;
			end
			S_PIX0: begin
				px_q <= px_c[8:0];
				py_q <= py_c[8:0];
			end
			S_PIX1: begin
				cx_q  <= cx_c[8:0];
				cy_q  <= cy_c[8:0];
				idx_q <= AW'(idx_c);
			end
			S_PIX2: cidx_q <= AW'(cidx_c);
			S_READ: begin
				if (rcnt_q != 3'd0) begin
					pv_q[rcnt_q - 3'd1] <= prv_rd;
				end
				if (rcnt_q == 3'd1) begin
					cv_q <= cur_rd;
				end
			end
			S_MUL: begin
				gxx_q  <= gx_c * gx_c;
				gxy_q  <= gx_c * gy_c;
				gyy_q  <= gy_c * gy_c;
				gxit_q <= gx_c * it_c;
				gyit_q <= gy_c * it_c;
			end
			S_ACC: begin
				sxx_q <= sxx_q + SW'(gxx_q);
				sxy_q <= sxy_q + SW'(gxy_q);
				syy_q <= syy_q + SW'(gyy_q);
				bx_q  <= bx_q - SW'(gxit_q);
				by_q  <= by_q - SW'(gyit_q);
			end
			S_SOLVE, S_SQ: mp_q[mstep_q] <= ma * mb;
			S_DET: begin
				det_q <= det_c;
				nx_q  <= NW'(nxd_c) <<< 9;
				ny_q  <= NW'(nyd_c) <<< 9;
				if (det_c == '0) begin
					status_q <= ST_ILL;
					u_q      <= '0;
					v_q      <= '0;
				end
			end
			S_DINIT: begin
				quo_q <= dmag_c;
				rem_q <= '0;
				neg_q <= dn_c < 0;
			end
			S_DIV: begin
				rem_q <= qbit_c ? PW'(shf_c - {1'b0, det_q}) : PW'(shf_c);
				quo_q <= {quo_q[NW-2:0], qbit_c};
			end
			S_DEND: begin
				if (dsel_q) begin
					dv_q <= dq_c;
				end else begin
					du_q <= dq_c;
				end
			end
			S_UPD: begin
				if (su_c > (NW+2)'(DISP_LIMIT)) begin
					u_q <= UW'(DISP_LIMIT);
				end else if (su_c < -(NW+2)'(DISP_LIMIT)) begin
					u_q <= -UW'(DISP_LIMIT);
				end else begin
					u_q <= UW'(su_c);
				end
				if (sv_c > (NW+2)'(DISP_LIMIT)) begin
					v_q <= UW'(DISP_LIMIT);
				end else if (sv_c < -(NW+2)'(DISP_LIMIT)) begin
					v_q <= -UW'(DISP_LIMIT);
				end else begin
					v_q <= UW'(sv_c);
				end
				dx_q  <= -wh_pos;
				dy_q  <= -wh_pos;
				sxx_q <= '0;
				sxy_q <= '0;
				syy_q <= '0;
				bx_q  <= '0;
				by_q  <= '0;
			end
			S_OUT: begin
				if (!m_tvalid) begin
					m_tdata <= {4'b0, oy_t, ox_t};
					m_tuser <= st_fin;
				end
			end
			default: ;
		endcase
		// Raster advance through the window once a pixel is used or skipped.
		if ((state_q == S_PIX0 && border) || (state_q == S_PIX1 && !cok)
				|| state_q == S_ACC) begin
			if (dx_q == wh_pos) begin
				dx_q <= -wh_pos;
				dy_q <= dy_q + DXW'(1);
			end else begin
				dx_q <= dx_q + DXW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (det_q != '0))
		else $error("divider running with a zero determinant");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX0) |-> (step_q < 3'(LK_STEPS)))
		else $error("track step count out of range");

	a_bank_write: assert property (@(posedge clk) disable iff (!arst_n)
		(we_a || we_b) |-> ((state_q == S_LOAD) && !(we_a && we_b)))
		else $error("bank write outside a load or to both banks");
`endif

endmodule
